>>> rtl/core/aminv_pkg.sv
// Shared types, widths and index tables for the affine 3x4 matrix inverse core.
// No dependencies; every other file imports this package.
package aminv_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [64:0] adj_t;
	typedef logic signed [96:0] wide_t;
	typedef logic [0:11][31:0] mat_vec_t;

	typedef struct packed {
		word_t a00; word_t a01; word_t a02; word_t a03;
		word_t a10; word_t a11; word_t a12; word_t a13;
		word_t a20; word_t a21; word_t a22; word_t a23;
	} mat_t;

	typedef struct packed {
		word_t inv00; word_t inv01; word_t inv02; word_t inv03;
		word_t inv10; word_t inv11; word_t inv12; word_t inv13;
		word_t inv20; word_t inv21; word_t inv22; word_t inv23;
	} inv_t;

	localparam int NCOF = 9;
	localparam int NDOT = 12;
	localparam int NMAT = 12;
	localparam int QW   = 32;

	// Cofactor c = x[p]*x[q] - x[r]*x[s], indices into the row-major 3x4 matrix
	localparam logic [3:0] COF_IDX [NCOF][4] = '{
		'{4'd5, 4'd10, 4'd6, 4'd9},
		'{4'd2, 4'd9,  4'd1, 4'd10},
		'{4'd1, 4'd6,  4'd2, 4'd5},
		'{4'd6, 4'd8,  4'd4, 4'd10},
		'{4'd0, 4'd10, 4'd2, 4'd8},
		'{4'd2, 4'd4,  4'd0, 4'd6},
		'{4'd4, 4'd9,  4'd5, 4'd8},
		'{4'd1, 4'd8,  4'd0, 4'd9},
		'{4'd0, 4'd5,  4'd1, 4'd4}
	};

	// Products adj*x: first three build the determinant, then three per translation row
	localparam logic [3:0] DOT_ADJ [NDOT] = '{
		4'd0, 4'd3, 4'd6, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8
	};
	localparam logic [3:0] DOT_X [NDOT] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd11, 4'd3, 4'd7, 4'd11, 4'd3, 4'd7, 4'd11
	};

endpackage

>>> rtl/core/aminv_cof.sv
// Cofactor stages: 2x2 products, then cofactor differences (two register stages).
// Depends on aminv_pkg.
module aminv_cof (
	input  logic                clk,
	input  aminv_pkg::mat_vec_t x,
	output aminv_pkg::adj_t     adj [aminv_pkg::NCOF],
	output aminv_pkg::mat_vec_t x_out
);
	import aminv_pkg::*;

	prod_t    pa_s1 [NCOF];
	prod_t    pb_s1 [NCOF];
	mat_vec_t x_s1;
	adj_t     cof_s2 [NCOF];
	mat_vec_t x_s2;

	// Form both products of every cofactor
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			pa_s1[i] <= $signed(x[COF_IDX[i][0]]) * $signed(x[COF_IDX[i][1]]);
			pb_s1[i] <= $signed(x[COF_IDX[i][2]]) * $signed(x[COF_IDX[i][3]]);
		end
		x_s1 <= x;
	end

	// Take the differences
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			cof_s2[i] <= adj_t'(pa_s1[i]) - adj_t'(pb_s1[i]);
		end
		x_s2 <= x_s1;
	end

	assign adj   = cof_s2;
	assign x_out = x_s2;

endmodule

>>> rtl/core/aminv_dot.sv
// Determinant and translation numerators: split products, joined products, sums.
// Three register stages. Depends on aminv_pkg.
module aminv_dot (
	input  logic                clk,
	input  aminv_pkg::adj_t     adj [aminv_pkg::NCOF],
	input  aminv_pkg::mat_vec_t x,
	output aminv_pkg::wide_t    det,
	output aminv_pkg::wide_t    num [3],
	output aminv_pkg::adj_t     adj_out [aminv_pkg::NCOF]
);
	import aminv_pkg::*;

	logic signed [64:0] lo_s1 [NDOT];
	logic signed [64:0] hi_s1 [NDOT];
	adj_t  adj_s1 [NCOF];
	wide_t full_s2 [NDOT];
	adj_t  adj_s2 [NCOF];
	wide_t det_s3;
	wide_t num_s3 [3];
	adj_t  adj_s3 [NCOF];

	// Split each 65-bit cofactor into a low and a high half and multiply
	always_ff @(posedge clk) begin
		for (int p = 0; p < NDOT; p++) begin
			lo_s1[p] <= $signed({1'b0, adj[DOT_ADJ[p]][31:0]}) * $signed(x[DOT_X[p]]);
			hi_s1[p] <= $signed(adj[DOT_ADJ[p]][64:32]) * $signed(x[DOT_X[p]]);
		end
		adj_s1 <= adj;
	end

	// Join the halves
	always_ff @(posedge clk) begin
		for (int p = 0; p < NDOT; p++) begin
			full_s2[p] <= (wide_t'(hi_s1[p]) <<< 32) + wide_t'(lo_s1[p]);
		end
		adj_s2 <= adj_s1;
	end

	// Sum three terms for the determinant and each numerator
	always_ff @(posedge clk) begin
		det_s3 <= full_s2[0] + full_s2[1] + full_s2[2];
		for (int j = 0; j < 3; j++) begin
			num_s3[j] <= full_s2[3 + 3*j] + full_s2[4 + 3*j] + full_s2[5 + 3*j];
		end
		adj_s3 <= adj_s2;
	end

	assign det     = det_s3;
	assign num     = num_s3;
	assign adj_out = adj_s3;

endmodule

>>> rtl/core/aminv_div.sv
// Pipelined restoring divider: overflow check, one quotient bit per stage, saturate.
// Each step is registered. Depends on aminv_pkg.
module aminv_div #(
	parameter int NMW = 112,
	parameter int DMW = 96
) (
	input  logic                 clk,
	input  logic [NMW-1:0]       n_mag,
	input  logic [DMW-1:0]       d_mag,
	input  logic                 neg,
	input  logic                 zero,
	output aminv_pkg::word_t     q
);
	import aminv_pkg::*;

	localparam int CW = (NMW > DMW + QW) ? NMW : DMW + QW;

	logic [CW-1:0]  rem_s [0:QW];
	logic [DMW-1:0] den_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic           neg_s [0:QW];
	logic           zero_s [0:QW];
	logic           sat_s [0:QW];
	word_t          q_q;
	logic [CW-1:0]  den_top;

	assign den_top = {{(CW-DMW){1'b0}}, d_mag} << QW;

	// Flag quotients of 2^32 or more
	always_ff @(posedge clk) begin
		rem_s[0]  <= {{(CW-NMW){1'b0}}, n_mag};
		den_s[0]  <= d_mag;
		quo_s[0]  <= '0;
		neg_s[0]  <= neg;
		zero_s[0] <= zero;
		sat_s[0]  <= ({{(CW-NMW){1'b0}}, n_mag} >= den_top);
	end

	// Resolve one quotient bit per stage, most significant first
	for (genvar g = 1; g <= QW; g++) begin : g_stage
		localparam int SH = QW - g;
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = {{(CW-DMW){1'b0}}, den_s[g-1]} << SH;
		assign ge  = rem_s[g-1] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? rem_s[g-1] - dsh : rem_s[g-1];
			quo_s[g]  <= {quo_s[g-1][QW-2:0], ge};
			den_s[g]  <= den_s[g-1];
			neg_s[g]  <= neg_s[g-1];
			zero_s[g] <= zero_s[g-1];
			sat_s[g]  <= sat_s[g-1];
		end
	end

	// Apply sign and saturate
	always_ff @(posedge clk) begin
		if (zero_s[QW]) begin
			q_q <= '0;
		end else if (!neg_s[QW]) begin
			if (sat_s[QW] || quo_s[QW][QW-1]) q_q <= 32'h7FFF_FFFF;
			else q_q <= quo_s[QW];
		end else begin
			if (sat_s[QW] || quo_s[QW] > 32'h8000_0000) q_q <= 32'h8000_0000;
			else q_q <= -quo_s[QW];
		end
	end

	assign q = q_q;

endmodule

>>> rtl/core/affine_matrix_inverse_core.sv
// Affine 3x4 matrix inverse core, signed fixed point with FRAC_BITS fraction bits.
// Depends on aminv_pkg, aminv_cof, aminv_dot and aminv_div.
//
// Usage: drive matrix (rows a00..a23, column 3 is translation) and raise start.
// The item is taken at every clock edge where start is high and busy is low;
// busy stays low, so one matrix may enter in every cycle.
// The inverse appears on result with done high for exactly one cycle.
// Throughput is one item per cycle. Each item passes the 32 quotient stages of the
// twelve parallel dividers and nine more: capture, products, cofactors, split
// and joined products, det/numerator sums, operand prep, overflow check, saturate.
// A zero determinant gives all-zero fields; out-of-range quotients saturate.
// Reset clears the valid line only, so no done strobe comes from items that
// were in flight. The receiver cannot stall; results must be taken as shown.
module affine_matrix_inverse_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  aminv_pkg::mat_t matrix,
	output logic            done,
	output aminv_pkg::inv_t result
);
	import aminv_pkg::*;

	localparam int DMW = 96;
	localparam int NMW = (64 + 2*FRAC_BITS > 96 + FRAC_BITS) ?
		64 + 2*FRAC_BITS : 96 + FRAC_BITS;
	localparam int LAT = 9 + QW;

	logic [LAT-1:0] vld_q;
	mat_vec_t       x_s1;
	adj_t           adj_c [NCOF];
	mat_vec_t       x_c;
	wide_t          det_d;
	wide_t          num_d [3];
	adj_t           adj_d [NCOF];
	logic [NMW-1:0] nmag_s7 [NMAT];
	logic           neg_s7 [NMAT];
	logic [DMW-1:0] dmag_s7;
	logic           zero_s7;
	logic [0:11][31:0] res_vec;

	assign busy = 1'b0;

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		x_s1 <= mat_vec_t'(matrix);
	end

	aminv_cof u_cof (
		.clk   (clk),
		.x     (x_s1),
		.adj   (adj_c),
		.x_out (x_c)
	);

	aminv_dot u_dot (
		.clk     (clk),
		.adj     (adj_c),
		.x       (x_c),
		.det     (det_d),
		.num     (num_d),
		.adj_out (adj_d)
	);

	// Prepare dividend magnitudes and signs
	always_ff @(posedge clk) begin
		wide_t det_abs;
		wide_t num_abs;
		adj_t  adj_abs;
		det_abs = det_d[96] ? -det_d : det_d;
		dmag_s7 <= det_abs[DMW-1:0];
		zero_s7 <= (det_d == '0);
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				adj_abs = adj_d[j*3 + k][64] ? -adj_d[j*3 + k] : adj_d[j*3 + k];
				nmag_s7[j*4 + k] <= {{(NMW-64){1'b0}}, adj_abs[63:0]} << (2*FRAC_BITS);
				neg_s7[j*4 + k]  <= adj_d[j*3 + k][64] ^ det_d[96];
			end
			num_abs = num_d[j][96] ? -num_d[j] : num_d[j];
			nmag_s7[j*4 + 3] <= {{(NMW-96){1'b0}}, num_abs[95:0]} << FRAC_BITS;
			neg_s7[j*4 + 3]  <= !num_d[j][96] ^ det_d[96];
		end
	end

	for (genvar e = 0; e < NMAT; e++) begin : g_div
		aminv_div #(
			.NMW (NMW),
			.DMW (DMW)
		) u_div (
			.clk   (clk),
			.n_mag (nmag_s7[e]),
			.d_mag (dmag_s7),
			.neg   (neg_s7[e]),
			.zero  (zero_s7),
			.q     (res_vec[e])
		);
	end

	assign result = inv_t'(res_vec);
	assign done   = vld_q[LAT-1];

endmodule
